[src/psrf_pkg.sv]
// ----------------------------------------------------------------------------
// psrf_pkg
// Widths, register indexes and reset values for the pair force pipeline.
// ----------------------------------------------------------------------------
package psrf_pkg;

   localparam int POS_W  = 32;
   localparam int ACC_W  = 48;
   localparam int CSR_W  = 32;
   localparam int CUT_W  = 31;
   localparam int MASS_W = 32;

   localparam logic [1:0] CSR_CUTOFF = 2'd0;
   localparam logic [1:0] CSR_MIN    = 2'd1;
   localparam logic [1:0] CSR_MASS   = 2'd2;

   localparam logic [CUT_W-1:0]  CUTOFF_RESET = 31'd167772;
   localparam logic [CUT_W-1:0]  MIN_RESET    = 31'd1678;
   localparam logic [MASS_W-1:0] MASS_RESET   = 32'd6553600;

   localparam logic [63:0] COEF_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [48:0] DELTA_MAX = 49'h1_0000_0000_0000;

   typedef struct packed {
      logic                     neg;
      logic [ACC_W-1:0]         acc_x;
      logic [ACC_W-1:0]         acc_y;
      logic [POS_W:0]           adx;
      logic [POS_W:0]           ady;
      logic                     sdx;
      logic                     sdy;
      logic                     in_range;
   } carry_type;

endpackage

[src/pairwise_short_range_force.sv]
// ----------------------------------------------------------------------------
// pairwise_short_range_force
// Short-range repulsive pair force between two particles in the plane.
// ----------------------------------------------------------------------------
// One word on the req_ channel carries a particle pair and the home particle's
// running acceleration; one word on the rsp_ channel returns the updated
// acceleration with the within_cutoff and saturated flags.
// The datapath is a linear pipeline: difference and squares, clamp, a
// one-bit-per-stage square root, two restoring dividers that retire one
// quotient bit per stage, the mass product and the saturating sums.
// A pair may enter in every cycle while req_stall is low. The pipeline has
// 169 register stages: three front stages, 32 for the square root, 64 for
// each divider, three for the mass product, two for the deltas and the
// output register.
// A stall on rsp_ freezes the whole pipeline, so req_stall
// follows rsp_stall while the output stage holds a word.
// Synchronous reset clears all valid bits and loads the register defaults.
// The user must write csr_ registers only while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pairwise_short_range_force (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [psrf_pkg::POS_W-1:0] req_self_x,
   input  logic signed [psrf_pkg::POS_W-1:0] req_self_y,
   input  logic signed [psrf_pkg::POS_W-1:0] req_other_x,
   input  logic signed [psrf_pkg::POS_W-1:0] req_other_y,
   input  logic signed [psrf_pkg::ACC_W-1:0] req_acc_in_x,
   input  logic signed [psrf_pkg::ACC_W-1:0] req_acc_in_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [psrf_pkg::ACC_W-1:0] rsp_acc_out_x,
   output logic signed [psrf_pkg::ACC_W-1:0] rsp_acc_out_y,
   output logic                              rsp_within_cutoff,
   output logic                              rsp_saturated,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [psrf_pkg::CSR_W-1:0]        csr_data
);

   localparam int SQ = 32;
   localparam int DV = 64;

   logic [psrf_pkg::CUT_W-1:0]  cut_ff, min_ff;
   logic [psrf_pkg::MASS_W-1:0] mass_ff;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff  <= psrf_pkg::CUTOFF_RESET;
         min_ff  <= psrf_pkg::MIN_RESET;
         mass_ff <= psrf_pkg::MASS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            psrf_pkg::CSR_CUTOFF: cut_ff  <= csr_data[psrf_pkg::CUT_W-1:0];
            psrf_pkg::CSR_MIN:    min_ff  <= csr_data[psrf_pkg::CUT_W-1:0];
            psrf_pkg::CSR_MASS:   mass_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Stage 1: differences and magnitudes.
   logic s1_v_ff;
   psrf_pkg::carry_type s1_ff;
   logic signed [psrf_pkg::POS_W:0] dx_w, dy_w;
   assign dx_w = {req_other_x[31], req_other_x} - {req_self_x[31], req_self_x};
   assign dy_w = {req_other_y[31], req_other_y} - {req_self_y[31], req_self_y};
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
      if (adv) begin
         s1_ff.acc_x    <= req_acc_in_x;
         s1_ff.acc_y    <= req_acc_in_y;
         s1_ff.sdx      <= dx_w[32];
         s1_ff.sdy      <= dy_w[32];
         s1_ff.adx      <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
         s1_ff.ady      <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
         s1_ff.neg      <= 1'b0;
         s1_ff.in_range <= 1'b0;
      end
   end

   // Stage 2: squares.
   logic s2_v_ff;
   psrf_pkg::carry_type s2_ff;
   logic [65:0] sqx_ff, sqy_ff;
   logic [61:0] cc_ff;
   logic        box_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
      if (adv) begin
         s2_ff  <= s1_ff;
         sqx_ff <= s1_ff.adx * s1_ff.adx;
         sqy_ff <= s1_ff.ady * s1_ff.ady;
         cc_ff  <= cut_ff * cut_ff;
         box_ff <= (s1_ff.adx <= 33'(cut_ff)) && (s1_ff.ady <= 33'(cut_ff));
      end
   end

   // Stage 3: sum, cutoff test and clamp.
   logic s3_v_ff;
   psrf_pkg::carry_type s3_ff, s3_in;
   logic [63:0] r2_ff;
   logic [66:0] r2_w;
   logic [61:0] mm_w;
   logic [30:0] m_w;
   assign r2_w = sqx_ff + sqy_ff;
   assign m_w  = (min_ff != '0) ? min_ff : 31'd1;
   assign mm_w = m_w * m_w;
   always_comb begin
      s3_in          = s2_ff;
      s3_in.in_range = box_ff && (r2_w <= 67'(cc_ff));
   end
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (adv) s3_v_ff <= s2_v_ff;
      if (adv) begin
         s3_ff <= s3_in;
         r2_ff <= (r2_w < 67'(mm_w)) ? 64'(mm_w) : r2_w[63:0];
      end
   end

   // Square root, one result bit per stage.
   logic                sq_v_ff [SQ+1];
   psrf_pkg::carry_type sq_c_ff [SQ+1];
   logic [63:0]         sq_r2_ff[SQ+1];
   logic [31:0]         sq_res_ff[SQ+1];
   always_comb begin
      sq_v_ff[0] = s3_v_ff; sq_c_ff[0] = s3_ff; sq_r2_ff[0] = r2_ff;
      sq_res_ff[0] = '0;
   end
   for (genvar i = 0; i < SQ; i++) begin : g_sq
      logic [63:0] t;
      logic [31:0] cand;
      assign cand = sq_res_ff[i] | (32'd1 << (SQ-1-i));
      assign t    = 64'(cand) * 64'(cand);
      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[i+1] <= 1'b0;
         else if (adv) sq_v_ff[i+1] <= sq_v_ff[i];
         if (adv) begin
            sq_c_ff[i+1]   <= sq_c_ff[i];
            sq_r2_ff[i+1]  <= sq_r2_ff[i];
            sq_res_ff[i+1] <= (t <= sq_r2_ff[i]) ? cand : sq_res_ff[i];
         end
      end
   end

   // a = |r - c|, numerator a << 24 for the first divider.
   logic                d1_v_ff [DV+1];
   psrf_pkg::carry_type d1_c_ff [DV+1];
   logic [63:0]         d1_r2_ff[DV+1];
   logic [63:0]         d1_n_ff [DV+1];
   logic [63:0]         d1_q_ff [DV+1];
   logic [32:0]         d1_rm_ff[DV+1];
   logic [31:0]         d1_d_ff [DV+1];
   logic [31:0]         r_w, a_w;
   logic                neg_w;
   assign r_w   = sq_res_ff[SQ];
   assign neg_w = r_w < 32'(cut_ff);
   assign a_w   = neg_w ? 32'(cut_ff) - r_w : r_w - 32'(cut_ff);
   always_comb begin
      d1_v_ff[0] = sq_v_ff[SQ];
      d1_c_ff[0] = sq_c_ff[SQ];
      d1_c_ff[0].neg = neg_w;
      d1_r2_ff[0] = sq_r2_ff[SQ];
      d1_n_ff[0] = 64'({a_w[31:0], 24'd0});
      d1_q_ff[0] = '0; d1_rm_ff[0] = '0; d1_d_ff[0] = r_w;
   end
   for (genvar i = 0; i < DV; i++) begin : g_d1
      logic [33:0] sh;
      assign sh = {d1_rm_ff[i], d1_n_ff[i][DV-1-i]};
      always_ff @(posedge clock) begin
         if (reset) d1_v_ff[i+1] <= 1'b0;
         else if (adv) d1_v_ff[i+1] <= d1_v_ff[i];
         if (adv) begin
            d1_c_ff[i+1]  <= d1_c_ff[i];
            d1_r2_ff[i+1] <= d1_r2_ff[i];
            d1_n_ff[i+1]  <= d1_n_ff[i];
            d1_d_ff[i+1]  <= d1_d_ff[i];
            if (sh >= 34'(d1_d_ff[i])) begin
               d1_rm_ff[i+1] <= 33'(sh - 34'(d1_d_ff[i]));
               d1_q_ff[i+1]  <= d1_q_ff[i] | (64'd1 << (DV-1-i));
            end else begin
               d1_rm_ff[i+1] <= 33'(sh);
               d1_q_ff[i+1]  <= d1_q_ff[i];
            end
         end
      end
   end

   // Second divider: (k << 40) / r2, hi part k >> 24 must stay below r2.
   logic                d2_v_ff [DV+1];
   psrf_pkg::carry_type d2_c_ff [DV+1];
   logic [63:0]         d2_n_ff [DV+1];
   logic [63:0]         d2_q_ff [DV+1];
   logic [64:0]         d2_rm_ff[DV+1];
   logic [63:0]         d2_d_ff [DV+1];
   logic                d2_of_ff[DV+1];
   logic [63:0]         k_w;
   assign k_w = d1_q_ff[DV];
   always_comb begin
      d2_v_ff[0] = d1_v_ff[DV]; d2_c_ff[0] = d1_c_ff[DV];
      d2_n_ff[0] = {k_w[23:0], 40'd0};
      d2_q_ff[0] = '0;
      d2_rm_ff[0] = 65'(k_w[63:24]);
      d2_d_ff[0] = d1_r2_ff[DV];
      d2_of_ff[0] = 64'(k_w[63:24]) >= d1_r2_ff[DV];
   end
   for (genvar i = 0; i < DV; i++) begin : g_d2
      logic [65:0] sh;
      assign sh = {d2_rm_ff[i], d2_n_ff[i][DV-1-i]};
      always_ff @(posedge clock) begin
         if (reset) d2_v_ff[i+1] <= 1'b0;
         else if (adv) d2_v_ff[i+1] <= d2_v_ff[i];
         if (adv) begin
            d2_c_ff[i+1]  <= d2_c_ff[i];
            d2_n_ff[i+1]  <= d2_n_ff[i];
            d2_d_ff[i+1]  <= d2_d_ff[i];
            d2_of_ff[i+1] <= d2_of_ff[i];
            if (sh >= 66'(d2_d_ff[i])) begin
               d2_rm_ff[i+1] <= 65'(sh - 66'(d2_d_ff[i]));
               d2_q_ff[i+1]  <= d2_q_ff[i] | (64'd1 << (DV-1-i));
            end else begin
               d2_rm_ff[i+1] <= 65'(sh);
               d2_q_ff[i+1]  <= d2_q_ff[i];
            end
         end
      end
   end

   // Coefficient g saturated, then the mass product in 32-bit partial products.
   logic                m1_v_ff, m2_v_ff, m3_v_ff;
   psrf_pkg::carry_type m1_c_ff, m2_c_ff, m3_c_ff;
   logic [63:0]         g_ff;
   logic                gs_ff, m2_s_ff, m3_s_ff;
   logic [63:0]         plo_ff, phi_ff;
   logic [63:0]         g_w;
   logic                gs_w;
   assign gs_w = d2_of_ff[DV] || d2_q_ff[DV][63];
   assign g_w  = gs_w ? psrf_pkg::COEF_MAX : d2_q_ff[DV];
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0; m2_v_ff <= 1'b0; m3_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff <= d2_v_ff[DV]; m2_v_ff <= m1_v_ff; m3_v_ff <= m2_v_ff;
      end
      if (adv) begin
         m1_c_ff <= d2_c_ff[DV]; g_ff <= g_w; gs_ff <= gs_w;
         m2_c_ff <= m1_c_ff; m2_s_ff <= gs_ff;
         plo_ff  <= g_ff[31:0] * mass_ff;
         phi_ff  <= g_ff[63:32] * mass_ff;
         m3_c_ff <= m2_c_ff;
      end
   end

   logic [96:0] pm_w;
   logic [80:0] cq_w;
   logic [63:0] cm_ff;
   logic        cms_w;
   assign pm_w  = 97'({phi_ff, 32'd0}) + 97'(plo_ff);
   assign cq_w  = pm_w[96:16];
   assign cms_w = cq_w > 81'(psrf_pkg::COEF_MAX);
   always_ff @(posedge clock) begin
      if (adv) begin
         cm_ff   <= cms_w ? psrf_pkg::COEF_MAX : cq_w[63:0];
         m3_s_ff <= m2_s_ff || cms_w;
      end
   end

   // Delta products: cm * |d|, split into two 32x33 partial products.
   logic                p_v_ff, q_v_ff;
   psrf_pkg::carry_type p_c_ff, q_c_ff;
   logic                p_s_ff, q_s_ff;
   logic [64:0]         xl_ff, xh_ff, yl_ff, yh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0; q_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= m3_v_ff; q_v_ff <= p_v_ff;
      end
      if (adv) begin
         p_c_ff <= m3_c_ff; p_s_ff <= m3_s_ff;
         xl_ff  <= cm_ff[31:0] * m3_c_ff.adx;
         xh_ff  <= cm_ff[63:32] * m3_c_ff.adx;
         yl_ff  <= cm_ff[31:0] * m3_c_ff.ady;
         yh_ff  <= cm_ff[63:32] * m3_c_ff.ady;
      end
   end

   logic [97:0] px_w, py_w;
   logic [48:0] dlx_ff, dly_ff;
   assign px_w = 98'({xh_ff, 32'd0}) + 98'(xl_ff);
   assign py_w = 98'({yh_ff, 32'd0}) + 98'(yl_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         q_c_ff <= p_c_ff; q_s_ff <= p_s_ff;
         dlx_ff <= (px_w[97:24] > 74'(psrf_pkg::DELTA_MAX)) ? psrf_pkg::DELTA_MAX
                   : px_w[72:24];
         dly_ff <= (py_w[97:24] > 74'(psrf_pkg::DELTA_MAX)) ? psrf_pkg::DELTA_MAX
                   : py_w[72:24];
      end
   end

   // Saturating sums and output register.
   logic signed [49:0] sx_w, sy_w;
   logic               ox_hi, ox_lo, oy_hi, oy_lo;
   always_comb begin
      sx_w = (q_c_ff.neg != q_c_ff.sdx)
             ? 50'(signed'(q_c_ff.acc_x)) - signed'(50'(dlx_ff))
             : 50'(signed'(q_c_ff.acc_x)) + signed'(50'(dlx_ff));
      sy_w = (q_c_ff.neg != q_c_ff.sdy)
             ? 50'(signed'(q_c_ff.acc_y)) - signed'(50'(dly_ff))
             : 50'(signed'(q_c_ff.acc_y)) + signed'(50'(dly_ff));
      ox_hi = sx_w > 50'sh7FFF_FFFF_FFFF;
      ox_lo = sx_w < -50'sh8000_0000_0000;
      oy_hi = sy_w > 50'sh7FFF_FFFF_FFFF;
      oy_lo = sy_w < -50'sh8000_0000_0000;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= q_v_ff;
      if (adv) begin
         rsp_within_cutoff <= q_c_ff.in_range;
         if (q_c_ff.in_range) begin
            rsp_acc_out_x <= ox_hi ? 48'sh7FFF_FFFF_FFFF : ox_lo ? 48'sh8000_0000_0000
                             : sx_w[47:0];
            rsp_acc_out_y <= oy_hi ? 48'sh7FFF_FFFF_FFFF : oy_lo ? 48'sh8000_0000_0000
                             : sy_w[47:0];
            rsp_saturated <= q_s_ff || ox_hi || ox_lo || oy_hi || oy_lo;
         end else begin
            rsp_acc_out_x <= q_c_ff.acc_x;
            rsp_acc_out_y <= q_c_ff.acc_y;
            rsp_saturated <= 1'b0;
         end
      end
   end

endmodule

[src/psrf_checker.sv]
// ----------------------------------------------------------------------------
// psrf_checker
// Port-level checks on the pair force pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module psrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [47:0] rsp_acc_out_x,
   input logic        rsp_within_cutoff,
   input logic        rsp_saturated
);

   a_stall_follow: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow the output stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_acc_out_x))
      else $error("stalled result word changed");

   a_sat_within: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_within_cutoff)
      else $error("saturation reported beyond cutoff");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pairwise_short_range_force psrf_checker u_psrf_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pair force pipeline.
// ----------------------------------------------------------------------------
// Pairs are offered in random bursts under several register settings. Each
// pair that is taken is predicted with wide integer arithmetic and queued. Each
// word that leaves is compared field by field with the oldest prediction. The
// receiver stalls on a pattern of its own, and once holds off for a long spell
// so that the pipeline fills and pushes back.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic signed [psrf_pkg::POS_W-1:0] self_x, self_y, other_x, other_y;
      logic signed [psrf_pkg::ACC_W-1:0] acc_x, acc_y;
   } pair_type;

   typedef struct {
      logic signed [psrf_pkg::ACC_W-1:0] acc_x, acc_y;
      bit                                in_range, sat;
   } force_type;

   localparam longint POS_LO = -64'sd2147483648;
   localparam longint POS_HI = 64'sd2147483647;
   localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint ACC_LO = -ACC_HI - 1;

   class force_scoreboard;
      logic [psrf_pkg::CUT_W-1:0]  cutoff;
      logic [psrf_pkg::CUT_W-1:0]  min_dist;
      logic [psrf_pkg::MASS_W-1:0] mass;
      force_type                   pending[$];
      int                          errors;

      function new();
         cutoff   = psrf_pkg::CUTOFF_RESET;
         min_dist = psrf_pkg::MIN_RESET;
         mass     = psrf_pkg::MASS_RESET;
         errors   = 0;
      endfunction

      task report(string msg);
         $display("tb_top: mismatch: %s", msg);
         errors++;
      endtask

      function logic [63:0] root_floor(logic [63:0] v);
         logic [63:0] res, t;
         res = 0;
         for (int i = 31; i >= 0; i--) begin
            t = res | (64'd1 << i);
            if (t * t <= v) res = t;
         end
         return res;
      endfunction

      function longint add_force(longint acc, logic [63:0] cm, logic [63:0] ad, bit down,
                                 inout bit sat);
         logic [127:0] w;
         longint       d, v;
         w = ({64'd0, cm} * {64'd0, ad}) >> 24;
         if (w > 128'(psrf_pkg::DELTA_MAX)) w = 128'(psrf_pkg::DELTA_MAX);
         d = longint'(w[63:0]);
         v = down ? acc - d : acc + d;
         if (v > ACC_HI) begin
            sat = 1;
            v = ACC_HI;
         end else if (v < ACC_LO) begin
            sat = 1;
            v = ACC_LO;
         end
         return v;
      endfunction

      function void note(pair_type p);
         longint       dx, dy, ax, ay;
         logic [63:0]  adx, ady, c, r2, m, r, a, k, g, cm;
         logic [127:0] w;
         bit           neg;
         force_type    o;
         ax = longint'(p.acc_x);
         ay = longint'(p.acc_y);
         dx = longint'(p.other_x) - longint'(p.self_x);
         dy = longint'(p.other_y) - longint'(p.self_y);
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         c = 64'(cutoff);
         o.in_range = 0;
         o.sat = 0;
         if (adx <= c && ady <= c) begin
            r2 = adx * adx + ady * ady;
            if (r2 <= c * c) begin
               o.in_range = 1;
               m = min_dist != 0 ? 64'(min_dist) : 64'd1;
               if (r2 < m * m) r2 = m * m;
               r = root_floor(r2);
               neg = r < c;
               a = neg ? c - r : r - c;
               k = (a << 24) / r;
               w = ({64'd0, k} << 40) / {64'd0, r2};
               if (w > 128'(psrf_pkg::COEF_MAX)) begin
                  o.sat = 1;
                  g = psrf_pkg::COEF_MAX;
               end else g = w[63:0];
               w = ({64'd0, g} * {96'd0, mass}) >> 16;
               if (w > 128'(psrf_pkg::COEF_MAX)) begin
                  o.sat = 1;
                  cm = psrf_pkg::COEF_MAX;
               end else cm = w[63:0];
               ax = add_force(ax, cm, adx, neg != (dx < 0), o.sat);
               ay = add_force(ay, cm, ady, neg != (dy < 0), o.sat);
            end
         end
         o.acc_x = ax[psrf_pkg::ACC_W-1:0];
         o.acc_y = ay[psrf_pkg::ACC_W-1:0];
         pending.push_back(o);
      endfunction

      task check(force_type got);
         force_type e;
         if (pending.size() == 0) begin
            report("word with no prediction waiting");
            return;
         end
         e = pending.pop_front();
         if (got.acc_x !== e.acc_x)
            report($sformatf("acc_out_x %h, predicted %h", got.acc_x, e.acc_x));
         if (got.acc_y !== e.acc_y)
            report($sformatf("acc_out_y %h, predicted %h", got.acc_y, e.acc_y));
         if (got.in_range !== e.in_range)
            report($sformatf("within_cutoff %b, predicted %b", got.in_range, e.in_range));
         if (got.sat !== e.sat)
            report($sformatf("saturated %b, predicted %b", got.sat, e.sat));
      endtask
   endclass

   logic                              clock = 0;
   logic                              reset = 1;
   logic                              req_valid = 0;
   logic                              req_stall;
   logic signed [psrf_pkg::POS_W-1:0] req_self_x = 0, req_self_y = 0;
   logic signed [psrf_pkg::POS_W-1:0] req_other_x = 0, req_other_y = 0;
   logic signed [psrf_pkg::ACC_W-1:0] req_acc_in_x = 0, req_acc_in_y = 0;
   logic                              rsp_valid;
   logic                              rsp_stall = 0;
   logic signed [psrf_pkg::ACC_W-1:0] rsp_acc_out_x, rsp_acc_out_y;
   logic                              rsp_within_cutoff, rsp_saturated;
   logic                              csr_write = 0;
   logic [1:0]                        csr_index = psrf_pkg::CSR_CUTOFF;
   logic [psrf_pkg::CSR_W-1:0]        csr_data = 0;

   force_scoreboard sb = new();
   int              words_out = 0;
   int              hold_left = 0;
   bit              held = 0;

   always #5 clock = ~clock;

   pairwise_short_range_force dut (.*);

   always @(posedge clock) begin
      force_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.acc_x    = rsp_acc_out_x;
            got.acc_y    = rsp_acc_out_y;
            got.in_range = rsp_within_cutoff;
            got.sat      = rsp_saturated;
            sb.check(got);
            words_out++;
         end
         if (!held && words_out >= 150) begin
            held = 1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if (words_out[9:7] < 3) begin
            rsp_stall <= 0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [psrf_pkg::CSR_W-1:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         psrf_pkg::CSR_CUTOFF: sb.cutoff   = value[psrf_pkg::CUT_W-1:0];
         psrf_pkg::CSR_MIN:    sb.min_dist = value[psrf_pkg::CUT_W-1:0];
         psrf_pkg::CSR_MASS:   sb.mass     = value[psrf_pkg::MASS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send(pair_type p);
      req_valid   <= 1;
      req_self_x  <= p.self_x;
      req_self_y  <= p.self_y;
      req_other_x <= p.other_x;
      req_other_y <= p.other_y;
      req_acc_in_x <= p.acc_x;
      req_acc_in_y <= p.acc_y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(p);
   endtask

   task automatic send_burst(pair_type list[$]);
      int left;
      left = 0;
      foreach (list[i]) begin
         if (left == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(posedge clock);
            left = $urandom_range(1, 40);
         end
         send(list[i]);
         left--;
      end
      req_valid <= 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (220) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic longint pick_offset(longint span);
      return longint'(rand64() % (2 * span + 1)) - span;
   endfunction

   function automatic longint place_self(longint d);
      longint lo, hi;
      lo = d < 0 ? POS_LO - d : POS_LO;
      hi = d < 0 ? POS_HI : POS_HI - d;
      return lo + longint'(rand64() % (hi - lo + 1));
   endfunction

   function automatic logic [psrf_pkg::ACC_W-1:0] random_acc();
      case ($urandom_range(0, 7))
         0: return 48'(ACC_HI - longint'($urandom_range(0, 1000)));
         1: return 48'(ACC_LO + longint'($urandom_range(0, 1000)));
         2: return 48'(longint'($urandom_range(0, 200000)) - 100000);
         default: return rand64()[47:0];
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      longint   span, dx, dy, sx, sy;
      int       mode;
      mode = $urandom_range(0, 9);
      if (mode < 2) span = longint'(sb.min_dist) * 2 + 2;
      else if (mode < 6) span = longint'(sb.cutoff) + 1;
      else if (mode < 8) span = longint'(sb.cutoff) * 2 + 2;
      else span = 64'sd4294967295;
      if (span > 64'sd4294967295) span = 64'sd4294967295;
      dx = pick_offset(span);
      dy = pick_offset(span);
      sx = place_self(dx);
      sy = place_self(dy);
      p.self_x  = 32'(sx);
      p.self_y  = 32'(sy);
      p.other_x = 32'(sx + dx);
      p.other_y = 32'(sy + dy);
      p.acc_x   = random_acc();
      p.acc_y   = random_acc();
      return p;
   endfunction

   function automatic pair_type make_pair(longint sx, longint sy, longint dx, longint dy,
                                          longint ax, longint ay);
      pair_type p;
      p.self_x  = 32'(sx);
      p.self_y  = 32'(sy);
      p.other_x = 32'(sx + dx);
      p.other_y = 32'(sy + dy);
      p.acc_x   = 48'(ax);
      p.acc_y   = 48'(ay);
      return p;
   endfunction

   initial begin
      pair_type list[$];
      longint   c;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      c = longint'(sb.cutoff);
      list.push_back(make_pair(POS_HI, POS_LO, POS_LO - POS_HI, POS_HI - POS_LO, 0, 0));
      list.push_back(make_pair(POS_LO, POS_HI, 0, 0, 0, 0));
      list.push_back(make_pair(100, -100, 0, 0, ACC_HI, ACC_LO));
      list.push_back(make_pair(0, 0, 1, 0, ACC_HI, ACC_LO));
      list.push_back(make_pair(0, 0, -1, 1, ACC_LO, ACC_HI));
      list.push_back(make_pair(5, 5, c, 0, 0, 0));
      list.push_back(make_pair(5, 5, -c, 0, 0, 0));
      list.push_back(make_pair(5, 5, c + 1, 0, 0, 0));
      list.push_back(make_pair(5, 5, 0, -c - 1, 0, 0));
      list.push_back(make_pair(-7, 9, c * 7 / 10, c * 7 / 10, 12345, -6789));
      list.push_back(make_pair(-7, 9, c * 3 / 4, -c * 3 / 4, 0, 0));
      list.push_back(make_pair(POS_HI - c, POS_LO, c, c / 2, ACC_HI, ACC_HI));
      list.push_back(make_pair(0, 0, longint'(sb.min_dist), 0, ACC_LO, ACC_LO));
      list.push_back(make_pair(0, 0, longint'(sb.min_dist) - 1, 1, 0, 0));
      list.push_back(make_pair(1000, 1000, -c / 3, c / 5, -1, 1));
      send_burst(list);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin
               write_reg(psrf_pkg::CSR_CUTOFF, 32'h7FFF_FFFF);
               write_reg(psrf_pkg::CSR_MIN, 32'd1);
               write_reg(psrf_pkg::CSR_MASS, 32'hFFFF_FFFF);
            end
            2: begin
               write_reg(psrf_pkg::CSR_CUTOFF, 32'h0100_0000);
               write_reg(psrf_pkg::CSR_MIN, 32'h0010_0000);
               write_reg(psrf_pkg::CSR_MASS, 32'd1);
            end
            3: begin
               write_reg(psrf_pkg::CSR_CUTOFF, 32'd1000);
               write_reg(psrf_pkg::CSR_MIN, 32'd5000);
               write_reg(psrf_pkg::CSR_MASS, 32'd65536);
            end
            4: begin
               write_reg(psrf_pkg::CSR_CUTOFF, 32'd1);
               write_reg(psrf_pkg::CSR_MIN, 32'h7FFF_FFFF);
               write_reg(psrf_pkg::CSR_MASS, 32'd12345);
            end
            default: ;
         endcase
         list.delete();
         for (int i = 0; i < 367; i++) list.push_back(random_pair());
         send_burst(list);
         drain();
      end

      if (sb.errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

[filelist.f]
src/psrf_pkg.sv
src/pairwise_short_range_force.sv
src/psrf_checker.sv
test/tb_top.sv
